// ===== hw/rtl/rational_arith_unit_defines.svh =====
// Shared assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Check that a condition always implies a consequence on the same edge
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int unsigned FieldWidthDefault = 32;
  localparam int unsigned InWidth  = 32;
  localparam int unsigned WideWidth = 64;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatOk   = 2'd0,
    StatZero = 2'd1,
    StatOvf  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture request, form magnitudes
    logic mul_step;  // one multiply phase
    logic sum;       // combine cross products
    logic gcd_start; // begin remainder loop
    logic gcd_step;  // one restoring-division bit
    logic gcd_swap;  // close one Euclid round
    logic div_start; // begin quotient division
    logic div_step;  // one quotient bit
    logic div_next;  // switch to denominator quotient
    logic finish;    // format result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad_in;   // zero denominator or divisor
    logic num_zero; // unreduced numerator is zero
    logic y_zero;   // gcd remainder operand is zero
    logic bit_last; // last bit of a serial division
    logic mul_last; // last multiply phase
  } stat_t;

endpackage

// ===== hw/rtl/rau_if.sv =====
interface rau_req_if;
  logic            valid;
  logic            ready;
  rau_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rau_rsp_if;
  logic            valid;
  logic            ready;
  rau_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rau_datapath.sv =====
module rau_datapath #(
  parameter int unsigned FieldWidth = rau_pkg::FieldWidthDefault
) (
  input  logic          clk_i,
  input  rau_pkg::req_t req_i,
  input  rau_pkg::cmd_t cmd_i,
  output rau_pkg::stat_t stat_o,
  output rau_pkg::rsp_t rsp_o
);
  localparam int unsigned W = rau_pkg::WideWidth;
  localparam int unsigned BitCntW = $clog2(W);
  localparam logic [W-1:0] Lim = W'(1) << (FieldWidth - 1);

  logic [1:0]    op_q;
  logic [31:0]   an_q, ad_q, bn_q, bd_q;
  logic          ann_q, adn_q, bnn_q, bdn_q;
  logic          bad_q;
  logic [W-1:0]  p1_q, p2_q;
  logic          p1n_q, p2n_q;
  logic [W-1:0]  num_q, den_q;
  logic          neg_q;
  logic [1:0]    mph_q;
  logic [W-1:0]  x_q, y_q, quo_q, rem_q, dvd_q;
  logic [BitCntW-1:0] bit_q;
  rau_pkg::rsp_t rsp_q;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Multiplier operands for each phase
  logic [31:0] ma, mb;
  logic [W-1:0] mprod;
  always_comb begin
    unique case (mph_q)
      2'd0:    begin ma = (op_q == rau_pkg::OpMul) ? an_q : an_q;
                     mb = (op_q == rau_pkg::OpMul) ? bn_q : bd_q; end
      2'd1:    begin ma = ad_q;
                     mb = (op_q == rau_pkg::OpDiv) ? bn_q : bd_q; end
      default: begin ma = bn_q; mb = ad_q; end
    endcase
    mprod = {32'd0, ma} * {32'd0, mb};
  end

  // Restoring division step on rem/quo
  logic [W:0] trial;
  logic [W-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, y_q};
  end

  logic [W-1:0] sum_mag;
  logic         sum_neg;
  logic         t2n;
  always_comb begin
    t2n = (op_q == rau_pkg::OpSub && p2_q != '0) ? ~p2n_q : p2n_q;
    if (p1n_q == t2n) begin
      sum_mag = p1_q + p2_q; sum_neg = p1n_q;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q; sum_neg = p1n_q;
    end else begin
      sum_mag = p2_q - p1_q; sum_neg = t2n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i.req_type;
      an_q <= mag32(req_i.a_num); ann_q <= req_i.a_num[31];
      ad_q <= mag32(req_i.a_den); adn_q <= req_i.a_den[31];
      bn_q <= mag32(req_i.b_num); bnn_q <= req_i.b_num[31];
      bd_q <= mag32(req_i.b_den); bdn_q <= req_i.b_den[31];
      bad_q <= (req_i.a_den == '0) || (req_i.b_den == '0) ||
               (req_i.req_type == rau_pkg::OpDiv && req_i.b_num == '0);
      mph_q <= 2'd0;
    end
    if (cmd_i.mul_step) begin
      mph_q <= mph_q + 2'd1;
      unique case (mph_q)
        2'd0: begin
          p1_q <= mprod;
          p1n_q <= ann_q ^ ((op_q == rau_pkg::OpMul) ? bnn_q : bdn_q);
        end
        2'd1: begin
          den_q <= mprod;
          neg_q <= adn_q ^ ((op_q == rau_pkg::OpDiv) ? bnn_q : bdn_q);
        end
        default: begin
          p2_q <= mprod; p2n_q <= bnn_q ^ adn_q;
        end
      endcase
    end
    if (cmd_i.sum) begin
      if (op_q == rau_pkg::OpAdd || op_q == rau_pkg::OpSub) begin
        num_q <= sum_mag; neg_q <= sum_neg ^ neg_q;
      end else begin
        num_q <= p1_q; neg_q <= p1n_q ^ neg_q;
      end
    end
    if (cmd_i.gcd_start) begin
      x_q <= num_q; y_q <= den_q;
    end
    if (cmd_i.gcd_start || cmd_i.gcd_swap) begin
      rem_q <= '0; bit_q <= '0;
      dvd_q <= cmd_i.gcd_start ? num_q : y_q;
    end
    if (cmd_i.gcd_swap) begin
      x_q <= y_q; y_q <= rem_q;
    end
    if (cmd_i.div_start) begin
      y_q <= x_q; dvd_q <= num_q; rem_q <= '0; bit_q <= '0;
    end
    if (cmd_i.div_next) begin
      num_q <= quo_q; dvd_q <= den_q; rem_q <= '0; bit_q <= '0;
    end
    if (cmd_i.gcd_step || cmd_i.div_step) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      bit_q <= bit_q + BitCntW'(1);
      quo_q <= {quo_q[W-2:0], ~trial[W]};
      rem_q <= trial[W] ? rem_sh : trial[W-1:0];
    end
    if (cmd_i.finish) begin
      if (bad_q) begin
        rsp_q <= '{res_num: '0, res_den: '0, status: rau_pkg::StatZero};
      end else if (num_q == '0) begin
        rsp_q <= '{res_num: '0, res_den: 31'd1, status: rau_pkg::StatOk};
      end else if (quo_q > Lim - W'(1) || num_q > (neg_q ? Lim : Lim - W'(1))) begin
        rsp_q <= '{res_num: '0, res_den: '0, status: rau_pkg::StatOvf};
      end else begin
        rsp_q <= '{res_num: neg_q ? (32'd0 - num_q[31:0]) : num_q[31:0],
                   res_den: quo_q[30:0], status: rau_pkg::StatOk};
      end
    end
  end

  // Division of gcd loop uses x as dividend: start sets dvd from num, swap from y
  always_comb begin
    stat_o.bad_in   = bad_q;
    stat_o.num_zero = (num_q == '0);
    stat_o.y_zero   = (y_q == '0);
    stat_o.bit_last = (bit_q == BitCntW'(W - 1));
    stat_o.mul_last = (mph_q == 2'd2);
  end

  assign rsp_o = rsp_q;
endmodule

// ===== hw/rtl/rau_ctrl.sv =====
`include "rational_arith_unit_defines.svh"
module rau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rau_pkg::stat_t stat_i,
  output rau_pkg::cmd_t  cmd_o
);
  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StMul   = 10'b0000000010,
    StSum   = 10'b0000000100,
    StGcdA  = 10'b0000001000,
    StGcdB  = 10'b0000010000,
    StSwap  = 10'b0000100000,
    StDivN  = 10'b0001000000,
    StDivSw = 10'b0010000000,
    StDivD  = 10'b0100000000,
    StFin   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   outv_q, outv_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    outv_d  = outv_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    if (outv_q && out_ready_i) outv_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.bad_in) state_d = StFin;
        else if (stat_i.mul_last) state_d = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1; state_d = StGcdA;
      end
      StGcdA: begin
        if (stat_i.num_zero) state_d = StFin;
        else begin
          cmd_o.gcd_start = 1'b1; state_d = StGcdB;
        end
      end
      StGcdB: begin
        if (stat_i.y_zero) begin
          cmd_o.div_start = 1'b1; state_d = StDivN;
        end else begin
          cmd_o.gcd_step = 1'b1;
          if (stat_i.bit_last) state_d = StSwap;
        end
      end
      StSwap: begin
        cmd_o.gcd_swap = 1'b1; state_d = StGcdB;
      end
      StDivN: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.bit_last) state_d = StDivSw;
      end
      StDivSw: begin
        cmd_o.div_next = 1'b1; state_d = StDivD;
      end
      StDivD: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.bit_last) state_d = StFin;
      end
      StFin: begin
        if (!outv_d) begin
          cmd_o.finish = 1'b1; outv_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; outv_q <= 1'b0;
    end else begin
      state_q <= state_d; outv_q <= outv_d;
    end
  end
  assign out_valid_o = outv_q;

  `RAU_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == StIdle, "ready outside idle")
  `RAU_ASSERT_NEXT(a_load_mul, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == StMul, "load did not start")
  `RAU_ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, cmd_o.finish, out_valid_o, "finish without valid")
endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// Channel | Dir | Payload
// req     | in  | req_type, a_num, a_den, b_num, b_den
// rsp     | out | res_num, res_den, status
// One request at a time; a bad input goes from the first multiply phase straight to the result,
// a zero numerator finishes after the sum, else the result follows up to about 92 Euclid rounds
// of the bit-serial remainder loop and two bit-serial quotient divisions.
// The three products share one 32x32 multiplier, one product per multiply phase.
// Reset clears the controller only; a held result lets the next request load.
module rational_arith_unit #(
  parameter int unsigned FIELD_WIDTH = rau_pkg::FieldWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);
  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  rau_datapath #(.FieldWidth(FIELD_WIDTH)) u_dp (
    .clk_i, .req_i(req.payload), .cmd_i(cmd), .stat_o(stat), .rsp_o(rsp.payload)
  );
endmodule
